>>> rtl/rie_pkg.sv
`default_nettype none
package rie_pkg;
  localparam int RegCount  = 16;
  localparam int DataWords = 4096;
  localparam int PcBits    = 10;
  localparam int AddrLimit = 4095;
  localparam int AddrBits  = $clog2(DataWords);

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_AND = 5'd2, OP_OR = 5'd3, OP_XOR = 5'd4,
    OP_MUL = 5'd5, OP_SLL = 5'd6, OP_SRA = 5'd7, OP_SRL = 5'd8,
    OP_BEQ = 5'd9, OP_BNE = 5'd10, OP_BLT = 5'd11, OP_BGT = 5'd12,
    OP_BLE = 5'd13, OP_BGE = 5'd14, OP_JAL = 5'd15, OP_LW = 5'd16,
    OP_SW = 5'd17, OP_HALT = 5'd20
  } opcode_e;

  typedef struct packed {
    logic        action;
    logic [4:0]  opcode;
    logic [3:0]  dest_reg;
    logic [3:0]  src_a_reg;
    logic [3:0]  src_b_reg;
    logic [3:0]  src_c_reg;
    logic [11:0] imm_first;
    logic [11:0] imm_second;
    logic [11:0] preload_addr;
    logic [31:0] preload_data;
  } item_t;

  typedef struct packed {
    logic [9:0]  next_pc;
    logic        halted;
    logic        reg_written;
    logic [3:0]  written_index;
    logic [31:0] written_value;
    logic        mem_written;
  } result_t;
endpackage
`default_nettype wire

>>> rtl/rie_item_if.sv
`default_nettype none
interface rie_item_if;
  import rie_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/rie_result_if.sv
`default_nettype none
interface rie_result_if;
  import rie_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/rie_queue.sv
`default_nettype none
// two-entry queue between front and back
module rie_queue import rie_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      push_data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output item_t      head_o
);
  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

>>> rtl/rie_back.sv
`default_nettype none
// Execute stage: registers, pc, halt and data memory. A lw waits for its memory
// word from a registered read before its beat is taken. Memory is cleared by a
// sweep after reset.
module rie_back import rie_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  empty_i,
  input  item_t      head_i,
  output logic       pop_o,
  rie_result_if.source res_o
);
  logic [31:0] regs_q [RegCount];
  logic [31:0] dmem [DataWords];
  logic [PcBits-1:0] pc_q;
  logic halt_q;
  logic [AddrBits:0] clr_q;
  logic clearing;
  assign clearing = ~clr_q[AddrBits];

  // load wait: 1 when the lw memory word is ready in rdata_q
  logic ld_q;
  logic [31:0] rdata_q;
  logic [AddrBits-1:0] raddr;

  logic        ov_q;
  result_t     ov_data_q;
  logic        can_go;

  function automatic logic [31:0] rd_reg(input logic [3:0] i, input item_t it,
                                         input logic [31:0] r [RegCount]);
    logic [31:0] v;
    v = 32'd0;
    if (i == 4'd1) v = {{20{it.imm_first[11]}}, it.imm_first};
    else if (i == 4'd2) v = {{20{it.imm_second[11]}}, it.imm_second};
    else if (i != 4'd0 && 32'(i) < RegCount) v = r[i[$clog2(RegCount)-1:0]];
    return v;
  endfunction

  logic [31:0] a, b, c, dv, wval;
  logic signed [32:0] addr;
  logic addr_ok, wr, mw, take, wrable, is_lw, mem_we;
  logic [PcBits-1:0] npc, pc1;
  logic halt_n;
  logic [4:0] sh;
  logic [63:0] prod;
  result_t rs;

  always_comb begin
    a  = rd_reg(head_i.src_a_reg, head_i, regs_q);
    b  = rd_reg(head_i.src_b_reg, head_i, regs_q);
    c  = rd_reg(head_i.src_c_reg, head_i, regs_q);
    dv = rd_reg(head_i.dest_reg, head_i, regs_q);
    sh = b[4:0];
    prod = a * b;
    addr = $signed({a[31], a}) + $signed({b[31], b});
    addr_ok = ~addr[32] && addr <= 33'sd4095 && addr < 33'(DataWords);
    wrable = head_i.dest_reg >= 4'd3 && 32'(head_i.dest_reg) < RegCount;
    pc1 = pc_q + 1'b1;
    npc = pc_q; wr = 1'b0; mw = 1'b0; wval = 32'd0; take = 1'b0;
    halt_n = halt_q; is_lw = 1'b0; mem_we = 1'b0;
    raddr = addr[AddrBits-1:0];
    if (head_i.action) begin
      mw = 32'(head_i.preload_addr) < DataWords;
      mem_we = mw;
    end else if (!halt_q) begin
      case (head_i.opcode)
        OP_ADD: begin wval = a + b + c; wr = 1'b1; npc = pc1; end
        OP_SUB: begin wval = a - b - c; wr = 1'b1; npc = pc1; end
        OP_AND: begin wval = a & b & c; wr = 1'b1; npc = pc1; end
        OP_OR:  begin wval = a | b | c; wr = 1'b1; npc = pc1; end
        OP_XOR: begin wval = a ^ b ^ c; wr = 1'b1; npc = pc1; end
        OP_MUL: begin wval = prod[31:0]; wr = 1'b1; npc = pc1; end
        OP_SLL: begin wval = a << sh; wr = 1'b1; npc = pc1; end
        OP_SRA: begin wval = $unsigned($signed(a) >>> sh); wr = 1'b1; npc = pc1; end
        OP_SRL: begin wval = a >> sh; wr = 1'b1; npc = pc1; end
        OP_BEQ, OP_BNE, OP_BLT, OP_BGT, OP_BLE, OP_BGE: begin
          case (head_i.opcode)
            OP_BEQ:  take = a == b;
            OP_BNE:  take = a != b;
            OP_BLT:  take = $signed(a) < $signed(b);
            OP_BGT:  take = $signed(a) > $signed(b);
            OP_BLE:  take = $signed(a) <= $signed(b);
            default: take = $signed(a) >= $signed(b);
          endcase
          npc = take ? c[PcBits-1:0] : pc1;
        end
        OP_JAL: begin
          if (wrable) begin
            wr = 1'b1; wval = 32'(pc1);
            // target reads after the link write
            npc = (head_i.src_c_reg == head_i.dest_reg) ? pc1 : c[PcBits-1:0];
          end else npc = pc1;
        end
        OP_LW: begin
          npc = pc1;
          if (addr_ok && wrable) begin
            is_lw = 1'b1; wr = 1'b1;
          end
        end
        OP_SW: begin
          npc = pc1;
          if (addr_ok) begin mw = 1'b1; mem_we = 1'b1; end
        end
        OP_HALT: halt_n = 1'b1;
        default: ;
      endcase
      if (!wrable) wr = 1'b0;
    end
    if (ld_q) wval = rdata_q + c;
    rs.next_pc = 10'(npc);
    rs.halted = halt_n;
    rs.reg_written = wr;
    rs.written_index = wr ? head_i.dest_reg : 4'd0;
    rs.written_value = wr ? wval : 32'd0;
    rs.mem_written = mw;
  end

  // output register frees up in the same cycle its beat is taken
  assign can_go = ~empty_i && ~clearing && (~ov_q || res_o.ready);
  // a load stalls for the registered memory read
  logic fire;
  assign fire  = can_go && (ld_q || !is_lw);
  assign pop_o = fire;

  always_ff @(posedge clk_i) begin
    if (clearing) dmem[clr_q[AddrBits-1:0]] <= 32'd0;
    else if (fire && mem_we)
      dmem[head_i.action ? head_i.preload_addr[AddrBits-1:0] : raddr] <=
        head_i.action ? head_i.preload_data : dv + c;
    rdata_q <= dmem[raddr];
    if (fire) ov_data_q <= rs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0; halt_q <= 1'b0; clr_q <= '0; ld_q <= 1'b0; ov_q <= 1'b0;
      regs_q <= '{default: 32'd0};
    end else begin
      if (clearing) clr_q <= clr_q + 1'b1;
      ld_q <= can_go && is_lw && !ld_q;
      if (fire && wr) regs_q[head_i.dest_reg[$clog2(RegCount)-1:0]] <= rs.written_value;
      if (fire) begin pc_q <= npc; halt_q <= halt_n; end
      if (fire) ov_q <= 1'b1;
      else if (res_o.ready) ov_q <= 1'b0;
    end
  end

  assign res_o.valid = ov_q;
  assign res_o.data  = ov_data_q;
endmodule
`default_nettype wire

>>> rtl/risc_instruction_execute.sv
`default_nettype none
// Items are queued, then executed into an output register; one beat per cycle while
// results are taken, except lw, which waits for its registered memory read.
// Results are held in an output register; a result not taken stalls execute.
// Reset clears registers, pc and halt; data memory is then swept to zero over all
// 4096 words, during which no item is executed.
module risc_instruction_execute import rie_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  rie_item_if.sink     in_i,
  rie_result_if.source out_o
);
  logic full, empty, pop;
  item_t head;
  assign in_i.ready = ~full;

  rie_queue u_queue (
    .clk_i, .rst_ni, .push_i(in_i.valid & ~full), .push_data_i(in_i.data),
    .full_o(full), .pop_i(pop), .empty_o(empty), .head_o(head)
  );

  rie_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .head_i(head), .pop_o(pop), .res_o(out_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop from empty queue");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && out_o.data.halted |=>
    !(out_o.valid && !out_o.data.halted)) else $error("halt cleared");
endmodule
`default_nettype wire

>>> tb/risc_instruction_execute_tb.sv
`timescale 1ns / 100ps
module risc_instruction_execute_tb;
  import rie_pkg::*;

  logic clk_i;
  logic rst_ni;

  rie_item_if   item_ch ();
  rie_result_if res_ch ();

  risc_instruction_execute u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_ch.sink),
    .out_o  (res_ch.source)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Machine state mirrored by the predictor
  logic [31:0]       regs_q [RegCount];
  logic [31:0]       dmem_q [DataWords];
  logic [PcBits-1:0] pc_q;
  logic              halt_q;

  item_t   pending_items [$];
  result_t expected_results [$];
  int      fail_cnt;
  bit      hold_active;
  int      hold_cycles;

  function automatic logic [31:0] read_gpr(logic [3:0] idx);
    if (idx == 4'd0 || idx >= RegCount) return 32'd0;
    return regs_q[idx];
  endfunction

  function automatic bit gpr_writable(logic [3:0] idx);
    return idx >= 4'd3 && idx < RegCount;
  endfunction

  // Execute one item against the mirrored machine and return its result.
  function automatic result_t execute_item(item_t it);
    result_t r;
    logic [31:0] a, b, c, wval;
    logic [PcBits-1:0] pc1, npc;
    longint addr;
    bit take, wr, mw;
    r = '0;
    wr = 0;
    mw = 0;
    take = 0;
    wval = '0;
    pc1 = pc_q + 1'b1;
    npc = pc_q;
    if (it.action) begin
      dmem_q[it.preload_addr] = it.preload_data;
      mw = 1;
    end else if (!halt_q) begin
      regs_q[1] = {{20{it.imm_first[11]}}, it.imm_first};
      regs_q[2] = {{20{it.imm_second[11]}}, it.imm_second};
      a = read_gpr(it.src_a_reg);
      b = read_gpr(it.src_b_reg);
      c = read_gpr(it.src_c_reg);
      addr = longint'($signed(a)) + longint'($signed(b));
      case (it.opcode)
        OP_ADD: begin wval = a + b + c; wr = 1; npc = pc1; end
        OP_SUB: begin wval = a - b - c; wr = 1; npc = pc1; end
        OP_AND: begin wval = a & b & c; wr = 1; npc = pc1; end
        OP_OR:  begin wval = a | b | c; wr = 1; npc = pc1; end
        OP_XOR: begin wval = a ^ b ^ c; wr = 1; npc = pc1; end
        OP_MUL: begin wval = a * b; wr = 1; npc = pc1; end
        OP_SLL: begin wval = a << b[4:0]; wr = 1; npc = pc1; end
        OP_SRA: begin wval = $signed(a) >>> b[4:0]; wr = 1; npc = pc1; end
        OP_SRL: begin wval = a >> b[4:0]; wr = 1; npc = pc1; end
        OP_BEQ: take = a == b;
        OP_BNE: take = a != b;
        OP_BLT: take = $signed(a) < $signed(b);
        OP_BGT: take = $signed(a) > $signed(b);
        OP_BLE: take = $signed(a) <= $signed(b);
        OP_BGE: take = $signed(a) >= $signed(b);
        OP_JAL: begin
          if (gpr_writable(it.dest_reg)) begin
            regs_q[it.dest_reg] = 32'(pc1);
            wval = 32'(pc1);
            wr = 1;
            npc = PcBits'(read_gpr(it.src_c_reg));
          end else begin
            npc = pc1;
          end
        end
        OP_LW: begin
          if (addr >= 0 && addr <= AddrLimit && addr < DataWords) begin
            wval = dmem_q[addr] + c;
            wr = 1;
          end
          npc = pc1;
        end
        OP_SW: begin
          if (addr >= 0 && addr <= AddrLimit && addr < DataWords) begin
            dmem_q[addr] = read_gpr(it.dest_reg) + c;
            mw = 1;
          end
          npc = pc1;
        end
        OP_HALT: halt_q = 1;
        default: ;
      endcase
      if (it.opcode >= OP_BEQ && it.opcode <= OP_BGE) npc = take ? c[PcBits-1:0] : pc1;
      if (it.opcode != OP_JAL && wr) begin
        if (gpr_writable(it.dest_reg)) regs_q[it.dest_reg] = wval;
        else wr = 0;
      end
      pc_q = npc;
    end
    r.next_pc = pc_q;
    r.halted = halt_q;
    r.reg_written = wr;
    r.written_index = wr ? it.dest_reg : 4'd0;
    r.written_value = wr ? wval : 32'd0;
    r.mem_written = mw;
    return r;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.action = 1'b0;
    it.opcode = ($urandom_range(0, 19) == 0) ? 5'($urandom) : 5'($urandom_range(0, 17));
    // halt is placed on purpose late in the run
    if (it.opcode == OP_HALT) it.opcode = OP_ADD;
    it.dest_reg = 4'($urandom);
    it.src_a_reg = 4'($urandom);
    it.src_b_reg = 4'($urandom);
    it.src_c_reg = 4'($urandom);
    it.imm_first = 12'($urandom);
    it.imm_second = 12'($urandom);
    // small values often, so memory addresses land in range
    if ($urandom_range(0, 1)) it.imm_first = 12'($urandom_range(0, 63));
    if ($urandom_range(0, 1)) it.imm_second = 12'($urandom_range(0, 63));
    it.preload_addr = 12'($urandom);
    it.preload_data = $urandom;
    return it;
  endfunction

  function automatic item_t make_exec(opcode_e op, logic [3:0] rd, logic [3:0] rs,
                                      logic [3:0] rt, logic [3:0] rm,
                                      logic [11:0] i1, logic [11:0] i2);
    item_t it;
    it = '0;
    it.opcode = op;
    it.dest_reg = rd;
    it.src_a_reg = rs;
    it.src_b_reg = rt;
    it.src_c_reg = rm;
    it.imm_first = i1;
    it.imm_second = i2;
    it.preload_addr = 12'($urandom);
    it.preload_data = $urandom;
    return it;
  endfunction

  function automatic item_t make_preload(logic [11:0] addr, logic [31:0] data);
    item_t it;
    it = rand_item();
    it.action = 1'b1;
    it.preload_addr = addr;
    it.preload_data = data;
    return it;
  endfunction

  // Driver
  int send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_ch.valid <= 1'b0;
      item_ch.data <= '0;
      send_gap <= 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        expected_results.push_back(execute_item(item_ch.data));
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          item_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          item_ch.valid <= 1'b1;
          item_ch.data <= pending_items.pop_front();
          send_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  int recv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      recv_gap <= 0;
      hold_cycles <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          fail_cnt++;
        end else begin
          exp_r = expected_results.pop_front();
          if (res_ch.data.next_pc !== exp_r.next_pc) begin
            $error("next_pc exp %0d got %0d", exp_r.next_pc, res_ch.data.next_pc);
            fail_cnt++;
          end
          if (res_ch.data.halted !== exp_r.halted) begin
            $error("halted exp %0d got %0d", exp_r.halted, res_ch.data.halted);
            fail_cnt++;
          end
          if (res_ch.data.reg_written !== exp_r.reg_written) begin
            $error("reg_written exp %0d got %0d", exp_r.reg_written,
                   res_ch.data.reg_written);
            fail_cnt++;
          end
          if (res_ch.data.written_index !== exp_r.written_index) begin
            $error("written_index exp %0d got %0d", exp_r.written_index,
                   res_ch.data.written_index);
            fail_cnt++;
          end
          if (res_ch.data.written_value !== exp_r.written_value) begin
            $error("written_value exp %h got %h", exp_r.written_value,
                   res_ch.data.written_value);
            fail_cnt++;
          end
          if (res_ch.data.mem_written !== exp_r.mem_written) begin
            $error("mem_written exp %0d got %0d", exp_r.mem_written,
                   res_ch.data.mem_written);
            fail_cnt++;
          end
        end
      end
      if (hold_active && hold_cycles < 200) begin
        hold_cycles <= hold_cycles + 1;
        res_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if (res_ch.valid && res_ch.ready)
          recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("risc_instruction_execute: mismatch");
    $finish;
  end

  initial begin
    item_t it;
    int n;
    fail_cnt = 0;
    hold_active = 0;
    for (int i = 0; i < RegCount; i++) regs_q[i] = '0;
    for (int i = 0; i < DataWords; i++) dmem_q[i] = '0;
    pc_q = '0;
    halt_q = 0;
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    res_ch.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, each opcode but halt, corner cases
    pending_items.push_back(make_preload(12'd4095, 32'hFFFF_FFFF));
    pending_items.push_back(make_preload(12'd0, 32'h8000_0001));
    pending_items.push_back(make_exec(OP_ADD, 4'd3, 4'd1, 4'd2, 4'd0, 12'h7FF, 12'h800));
    pending_items.push_back(make_exec(OP_SUB, 4'd4, 4'd1, 4'd2, 4'd3, 12'h800, 12'h7FF));
    pending_items.push_back(make_exec(OP_AND, 4'd5, 4'd1, 4'd2, 4'd4, 12'hFFF, 12'hAAA));
    pending_items.push_back(make_exec(OP_OR, 4'd6, 4'd1, 4'd2, 4'd0, 12'h555, 12'h0AA));
    pending_items.push_back(make_exec(OP_XOR, 4'd15, 4'd1, 4'd2, 4'd6, 12'h123, 12'hFFF));
    pending_items.push_back(make_exec(OP_MUL, 4'd7, 4'd1, 4'd2, 4'd0, 12'h800, 12'h800));
    pending_items.push_back(make_exec(OP_SLL, 4'd8, 4'd1, 4'd2, 4'd0, 12'hFFF, 12'h01F));
    pending_items.push_back(make_exec(OP_SRA, 4'd9, 4'd1, 4'd2, 4'd0, 12'h800, 12'h03F));
    pending_items.push_back(make_exec(OP_SRL, 4'd10, 4'd1, 4'd2, 4'd0, 12'h800, 12'h024));
    pending_items.push_back(make_exec(OP_ADD, 4'd0, 4'd1, 4'd2, 4'd0, 12'h001, 12'h001));
    pending_items.push_back(make_exec(OP_ADD, 4'd2, 4'd1, 4'd1, 4'd0, 12'h001, 12'h001));
    pending_items.push_back(make_exec(OP_BEQ, 4'd0, 4'd1, 4'd2, 4'd1, 12'h3FF, 12'h3FF));
    pending_items.push_back(make_exec(OP_BNE, 4'd0, 4'd1, 4'd2, 4'd2, 12'h001, 12'h005));
    pending_items.push_back(make_exec(OP_BLT, 4'd0, 4'd1, 4'd2, 4'd2, 12'hFFF, 12'h010));
    pending_items.push_back(make_exec(OP_BGT, 4'd0, 4'd1, 4'd2, 4'd2, 12'hFFF, 12'h010));
    pending_items.push_back(make_exec(OP_BLE, 4'd0, 4'd1, 4'd2, 4'd1, 12'h020, 12'h020));
    pending_items.push_back(make_exec(OP_BGE, 4'd0, 4'd1, 4'd2, 4'd1, 12'h030, 12'h020));
    pending_items.push_back(make_exec(OP_JAL, 4'd11, 4'd0, 4'd0, 4'd11, 12'h0, 12'h0));
    pending_items.push_back(make_exec(OP_JAL, 4'd1, 4'd0, 4'd0, 4'd5, 12'h0, 12'h0));
    pending_items.push_back(make_exec(OP_SW, 4'd6, 4'd1, 4'd2, 4'd2, 12'h7FF, 12'h7FF));
    pending_items.push_back(make_exec(OP_LW, 4'd12, 4'd1, 4'd2, 4'd1, 12'h7FF, 12'h800));
    pending_items.push_back(make_exec(OP_LW, 4'd12, 4'd1, 4'd2, 4'd0, 12'h7FF, 12'h7FF));
    pending_items.push_back(make_exec(opcode_e'(5'd31), 4'd3, 4'd1, 4'd2, 4'd0, 12'h1, 12'h1));

    // Random: mostly live execution, some preloads, one halt late in the run
    n = 0;
    while (n < 1300) begin
      if ($urandom_range(0, 9) == 0) it = make_preload(12'($urandom), $urandom);
      else it = rand_item();
      if (n == 1290) begin
        it = rand_item();
        it.opcode = OP_HALT;
      end
      pending_items.push_back(it);
      n++;
    end
    pending_items.push_back(make_exec(OP_ADD, 4'd3, 4'd1, 4'd2, 4'd0, 12'h1, 12'h1));
    pending_items.push_back(make_preload(12'd7, 32'h1234_5678));

    // long receiver hold while the sender keeps offering
    wait (pending_items.size() < 900);
    hold_active = 1;

    wait (pending_items.size() == 0);
    hold_active = 0;
    while (expected_results.size() > 0 || item_ch.valid) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("risc_instruction_execute: match");
    end else begin
      $display("risc_instruction_execute: mismatch");
    end
    $finish;
  end
endmodule
